// ----- rtl/core/exon_coordinate_mapper_assert.svh -----
// Assertion macros shared by the checker.
`ifndef EXON_COORDINATE_MAPPER_ASSERT_SVH
`define EXON_COORDINATE_MAPPER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define ECM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("exon mapper check failed");

// Next-cycle implication, masked during reset.
`define ECM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("exon mapper check failed");

// Next-cycle implication that also holds across reset.
`define ECM_ASSERT_RAW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("exon mapper check failed");

`endif

// ----- rtl/core/ecm_pkg.sv -----
package ecm_pkg;

  localparam int MAX_EXONS = 64;
  localparam int IDX_W     = $clog2(MAX_EXONS);
  localparam int CNT_W     = 7;
  localparam int POS_W     = 32;
  localparam int OP_W      = 3;
  // Signed width that holds any sum of exon and intron lengths plus a position.
  localparam int ACC_W     = POS_W + IDX_W + 4;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_G2S   = 3'd1;
  localparam logic [OP_W-1:0] OP_S2G   = 3'd2;
  localparam logic [OP_W-1:0] OP_G2U   = 3'd3;
  localparam logic [OP_W-1:0] OP_LEN   = 3'd4;

  // Configuration register indexes
  localparam logic CFG_STRAND = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  typedef struct packed {
    logic             start;
    logic             step;
    logic             first;
    logic             finish;
    logic [IDX_W-1:0] rd_addr;
  } ecm_cmd_t;

  typedef struct packed {
    logic hit;
  } ecm_sts_t;

endpackage

// ----- rtl/core/ecm_if.sv -----
interface ecm_req_if;
  logic                          valid;
  logic                          ready;
  logic [ecm_pkg::OP_W-1:0]      op;
  logic [ecm_pkg::IDX_W-1:0]     exon_slot;
  logic [ecm_pkg::POS_W-1:0]     exon_first;
  logic [ecm_pkg::POS_W-1:0]     exon_last;
  logic [ecm_pkg::POS_W-1:0]     position;

  modport source (output valid, op, exon_slot, exon_first, exon_last, position,
                  input ready);
  modport sink (input valid, op, exon_slot, exon_first, exon_last, position,
                output ready);
endinterface

interface ecm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ecm_pkg::POS_W-1:0] mapped_position;
  logic                      found;

  modport source (output valid, mapped_position, found, input ready);
  modport sink (input valid, mapped_position, found, output ready);
endinterface

// ----- rtl/core/ecm_datapath.sv -----
module ecm_datapath (
  input  logic                        clk,
  input  logic                        minus_strand,
  input  ecm_pkg::ecm_cmd_t           cmd,
  output ecm_pkg::ecm_sts_t           sts,
  input  logic [ecm_pkg::OP_W-1:0]    in_op,
  input  logic [ecm_pkg::IDX_W-1:0]   in_slot,
  input  logic [ecm_pkg::POS_W-1:0]   in_first,
  input  logic [ecm_pkg::POS_W-1:0]   in_last,
  input  logic [ecm_pkg::POS_W-1:0]   in_position,
  output logic [ecm_pkg::POS_W-1:0]   mapped_position,
  output logic                        found
);

  localparam int AW = ecm_pkg::ACC_W;
  localparam int PW = ecm_pkg::POS_W;

  logic [PW-1:0] lo_mem [ecm_pkg::MAX_EXONS];
  logic [PW-1:0] hi_mem [ecm_pkg::MAX_EXONS];
  logic [PW-1:0] rd_lo;
  logic [PW-1:0] rd_hi;

  logic [ecm_pkg::OP_W-1:0] op;
  logic [PW-1:0]            pos;
  logic signed [AW-1:0]     acc;
  logic signed [AW-1:0]     acc_next;
  logic signed [AW-1:0]     introns;
  logic signed [AW-1:0]     introns_next;
  logic signed [AW-1:0]     off;
  logic                     hit;
  logic [PW-1:0]            prev_lo;
  logic [PW-1:0]            prev_hi;
  logic [PW-1:0]            head_lo;
  logic [PW-1:0]            head_hi;

  logic signed [AW-1:0] lo_s, hi_s, pos_s, plo_s, phi_s, hlo_s, hhi_s;
  logic signed [AW-1:0] len, intron, gap, off_now, acc_gap;
  logic                 in_exon;
  logic                 hit_now;
  logic signed [AW-1:0] value;
  logic                 found_raw;
  logic                 in_range;

  always_ff @(posedge clk) begin
    if (cmd.start && in_op == ecm_pkg::OP_WRITE) begin
      lo_mem[in_slot] <= in_first;
      hi_mem[in_slot] <= in_last;
    end
    rd_lo <= lo_mem[cmd.rd_addr];
    rd_hi <= hi_mem[cmd.rd_addr];
  end

  assign lo_s  = AW'(rd_lo);
  assign hi_s  = AW'(rd_hi);
  assign pos_s = AW'(pos);
  assign plo_s = AW'(prev_lo);
  assign phi_s = AW'(prev_hi);
  assign hlo_s = AW'(head_lo);
  assign hhi_s = AW'(head_hi);

  always_comb begin
    len     = hi_s - lo_s + AW'(1);
    intron  = minus_strand ? (plo_s - AW'(1) - hi_s) : (lo_s - AW'(1) - phi_s);
    gap     = cmd.first ? '0 : intron;
    off_now = minus_strand ? (hi_s - pos_s) : (pos_s - lo_s);
    in_exon = (pos_s >= lo_s) && (pos_s <= hi_s);
    acc_gap = acc + gap;
    acc_next     = acc;
    introns_next = introns;
    hit_now      = 1'b0;
    case (op)
      ecm_pkg::OP_G2S: begin
        hit_now = in_exon;
        if (!in_exon) acc_next = acc + len;
      end
      ecm_pkg::OP_S2G: begin
        acc_next     = acc + len;
        introns_next = introns + gap;
        hit_now      = acc_next > pos_s;
      end
      ecm_pkg::OP_G2U: begin
        hit_now  = in_exon;
        acc_next = in_exon ? acc_gap : (acc_gap + len);
      end
      ecm_pkg::OP_LEN: acc_next = acc + len;
      default: ;
    endcase
  end

  assign sts.hit = cmd.step && hit_now;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op      <= in_op;
      pos     <= in_position;
      acc     <= '0;
      introns <= '0;
      hit     <= 1'b0;
    end else if (cmd.step) begin
      acc     <= acc_next;
      introns <= introns_next;
      prev_lo <= rd_lo;
      prev_hi <= rd_hi;
      if (cmd.first) begin
        head_lo <= rd_lo;
        head_hi <= rd_hi;
      end
      if (hit_now) begin
        hit <= 1'b1;
        off <= off_now;
      end
    end
  end

  // Final sum and range check on the registered walk state, captured when the controller finishes.
  always_comb begin
    value     = '0;
    found_raw = 1'b0;
    case (op) inside
      ecm_pkg::OP_G2S, ecm_pkg::OP_G2U: begin
        value     = off + acc;
        found_raw = hit;
      end
      ecm_pkg::OP_S2G: begin
        value     = minus_strand ? (hhi_s - pos_s - introns) : (hlo_s + introns + pos_s);
        found_raw = hit;
      end
      ecm_pkg::OP_LEN: begin
        value     = acc;
        found_raw = 1'b1;
      end
      default: ;
    endcase
    in_range = (value[AW-1:PW] == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found           <= found_raw && in_range;
      mapped_position <= (found_raw && in_range) ? value[PW-1:0] : '0;
    end
  end

endmodule

// ----- rtl/core/ecm_ctrl.sv -----
module ecm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ecm_pkg::CNT_W-1:0]   active_count,
  input  logic                        req_valid,
  input  logic [ecm_pkg::OP_W-1:0]    req_op,
  output logic                        req_ready,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output ecm_pkg::ecm_cmd_t           cmd,
  input  ecm_pkg::ecm_sts_t           sts
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [ecm_pkg::IDX_W-1:0] idx;
  logic                      accept;
  logic                      walk_op;
  logic                      last;
  logic                      slot_free;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign walk_op   = (req_op >= ecm_pkg::OP_G2S) && (req_op <= ecm_pkg::OP_LEN) &&
                     (active_count != '0);
  assign last      = (ecm_pkg::CNT_W'(idx) == active_count - ecm_pkg::CNT_W'(1));
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next  = state;
    cmd.start   = 1'b0;
    cmd.step    = 1'b0;
    cmd.first   = (idx == '0);
    cmd.finish  = 1'b0;
    cmd.rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.start  = 1'b1;
          state_next = walk_op ? S_WALK : S_FINISH;
        end
      end
      S_WALK: begin
        cmd.step    = 1'b1;
        cmd.rd_addr = idx + ecm_pkg::IDX_W'(1);
        if (sts.hit || last) state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) idx <= '0;
      else if (cmd.step) idx <= idx + ecm_pkg::IDX_W'(1);
      if (cmd.finish) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/exon_coordinate_mapper.sv -----
// A write, an unused code or a query on an empty table goes straight to the finish state
// once the request is taken; other queries first walk k table entries (1..64), one per
// cycle through the single read port. One request is in flight at a time: a new one is
// taken once the last has finished, and a stalled result holds off the next result. Reset
// clears the controller and the output valid, and sets plus strand, count 1; the exon
// table is undefined until written.
module exon_coordinate_mapper (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ecm_pkg::CNT_W-1:0]   cfg_data,
  ecm_req_if.sink                     req,
  ecm_rsp_if.source                   rsp
);

  logic                      minus_strand;
  logic [ecm_pkg::CNT_W-1:0] exon_count;
  logic [ecm_pkg::CNT_W-1:0] active_count;
  ecm_pkg::ecm_cmd_t         cmd;
  ecm_pkg::ecm_sts_t         sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      minus_strand <= 1'b0;
      exon_count   <= ecm_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ecm_pkg::CFG_STRAND: minus_strand <= cfg_data[0];
        ecm_pkg::CFG_COUNT:  exon_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate the count at the table depth
  assign active_count = (exon_count > ecm_pkg::CNT_W'(ecm_pkg::MAX_EXONS)) ?
                        ecm_pkg::CNT_W'(ecm_pkg::MAX_EXONS) : exon_count;

  ecm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .active_count (active_count),
    .req_valid    (req.valid),
    .req_op       (req.op),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  ecm_datapath u_datapath (
    .clk             (clk),
    .minus_strand    (minus_strand),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (req.op),
    .in_slot         (req.exon_slot),
    .in_first        (req.exon_first),
    .in_last         (req.exon_last),
    .in_position     (req.position),
    .mapped_position (rsp.mapped_position),
    .found           (rsp.found)
  );

endmodule

// ----- rtl/core/ecm_checker.sv -----
`include "exon_coordinate_mapper_assert.svh"

module ecm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [ecm_pkg::POS_W-1:0] mapped_position,
  input logic                      found
);

  // a miss always carries a zero position
  `ECM_ASSERT_NOW(a_miss_zero, clk, rst, rsp_valid && !found, mapped_position == '0)
  // one request at a time: ready drops after each accepted request
  `ECM_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)
  // a stalled result holds its value
  `ECM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(mapped_position) && $stable(found))
  // no result straight out of reset
  `ECM_ASSERT_RAW(a_reset_empty, clk, rst, !rsp_valid)

endmodule

bind exon_coordinate_mapper ecm_checker u_ecm_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .mapped_position (rsp.mapped_position),
  .found           (rsp.found)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam logic [ecm_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [ecm_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [ecm_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int     TARGET_ITEMS  = 1950;
  localparam int     PHASE_ITEMS   = 120;
  localparam int     CYCLE_LIMIT   = 2000000;
  localparam int     DRAIN_CYCLES  = 2 * ecm_pkg::MAX_EXONS + 8;
  localparam int     REPORT_LIMIT  = 100;
  localparam longint POS_MAX       = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [ecm_pkg::OP_W-1:0]  op;
    logic [ecm_pkg::IDX_W-1:0] slot;
    logic [ecm_pkg::POS_W-1:0] first;
    logic [ecm_pkg::POS_W-1:0] last;
    logic [ecm_pkg::POS_W-1:0] position;
  } map_req_t;

  typedef struct packed {
    logic [ecm_pkg::POS_W-1:0] mapped;
    logic                      found;
  } map_rsp_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [ecm_pkg::CNT_W-1:0] cfg_data;

  ecm_req_if req_ch ();
  ecm_rsp_if rsp_ch ();

  exon_coordinate_mapper DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Predictor copy of the exon table and registers, updated as requests are taken
  logic [ecm_pkg::POS_W-1:0] tbl_first [ecm_pkg::MAX_EXONS];
  logic [ecm_pkg::POS_W-1:0] tbl_last  [ecm_pkg::MAX_EXONS];
  logic                      tbl_minus;
  logic [ecm_pkg::CNT_W-1:0] tbl_count;

  // Generator's view of the table, runs ahead of the predictor
  logic [ecm_pkg::POS_W-1:0] plan_first [ecm_pkg::MAX_EXONS];
  logic [ecm_pkg::POS_W-1:0] plan_last  [ecm_pkg::MAX_EXONS];
  logic                      plan_minus;
  int                        plan_count;

  map_req_t req_backlog [$];
  map_rsp_t pending_maps [$];
  map_req_t next_req;
  map_rsp_t due;
  map_rsp_t predicted;
  bit       req_taken;
  int       send_idle;
  int       recv_stall;
  int       mismatches;
  int       cycles;
  int       items_made;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint lo_at(int i);
    return longint'({32'd0, tbl_first[i]});
  endfunction

  function automatic longint hi_at(int i);
    return longint'({32'd0, tbl_last[i]});
  endfunction

  // Intron ahead of exon i in walk order
  function automatic longint intron_ahead(int i);
    if (tbl_minus) return lo_at(i - 1) - 1 - hi_at(i);
    return lo_at(i) - 1 - hi_at(i - 1);
  endfunction

  function automatic map_rsp_t predict_mapping(map_req_t r);
    map_rsp_t res;
    longint   pos;
    longint   acc;
    longint   introns;
    longint   val;
    int       n;
    int       i;
    bit       ok;
    bit       done;
    pos = longint'({32'd0, r.position});
    n = (tbl_count > ecm_pkg::MAX_EXONS) ? ecm_pkg::MAX_EXONS : int'(tbl_count);
    acc = 0;
    introns = 0;
    val = 0;
    ok = 1'b0;
    done = 1'b0;
    case (r.op)
      ecm_pkg::OP_WRITE: begin
        tbl_first[r.slot] = r.first;
        tbl_last[r.slot] = r.last;
      end
      ecm_pkg::OP_G2S: begin
        for (i = 0; i < n && !done; i++) begin
          if (pos >= lo_at(i) && pos <= hi_at(i)) begin
            val = (tbl_minus ? hi_at(i) - pos : pos - lo_at(i)) + acc;
            ok = 1'b1;
            done = 1'b1;
          end else begin
            acc += hi_at(i) - lo_at(i) + 1;
          end
        end
      end
      ecm_pkg::OP_S2G: begin
        for (i = 0; i < n && !done; i++) begin
          acc += hi_at(i) - lo_at(i) + 1;
          if (i > 0) introns += intron_ahead(i);
          if (acc > pos) begin
            val = tbl_minus ? hi_at(0) - (pos + introns) : lo_at(0) + introns + pos;
            ok = 1'b1;
            done = 1'b1;
          end
        end
      end
      ecm_pkg::OP_G2U: begin
        for (i = 0; i < n && !done; i++) begin
          if (i > 0) acc += intron_ahead(i);
          if (pos >= lo_at(i) && pos <= hi_at(i)) begin
            val = (tbl_minus ? hi_at(i) - pos : pos - lo_at(i)) + acc;
            ok = 1'b1;
            done = 1'b1;
          end else begin
            acc += hi_at(i) - lo_at(i) + 1;
          end
        end
      end
      ecm_pkg::OP_LEN: begin
        for (i = 0; i < n; i++) val += hi_at(i) - lo_at(i) + 1;
        ok = 1'b1;
      end
      default: ;
    endcase
    if (!ok || val < 0 || val > POS_MAX) begin
      res = '0;
    end else begin
      res.mapped = ecm_pkg::POS_W'(val);
      res.found = 1'b1;
    end
    return res;
  endfunction

  function automatic void add_item(logic [ecm_pkg::OP_W-1:0] op,
                                   logic [ecm_pkg::IDX_W-1:0] slot,
                                   logic [ecm_pkg::POS_W-1:0] first,
                                   logic [ecm_pkg::POS_W-1:0] last,
                                   logic [ecm_pkg::POS_W-1:0] pos);
    map_req_t r;
    r.op = op;
    r.slot = slot;
    r.first = first;
    r.last = last;
    r.position = pos;
    req_backlog = {req_backlog, r};
    items_made++;
    if (op == ecm_pkg::OP_WRITE) begin
      plan_first[slot] = first;
      plan_last[slot] = last;
    end
  endfunction

  // Exon fields and slot are don't-care for queries: randomise them
  function automatic void add_query(logic [ecm_pkg::OP_W-1:0] op,
                                    logic [ecm_pkg::POS_W-1:0] pos);
    add_item(op, ecm_pkg::IDX_W'($urandom()), $urandom(), $urandom(), pos);
  endfunction

  function automatic int active_exons();
    return (plan_count > ecm_pkg::MAX_EXONS) ? ecm_pkg::MAX_EXONS : plan_count;
  endfunction

  function automatic int pick_scale();
    case ($urandom_range(3))
      0:       return 1;
      1:       return 16;
      2:       return 2000;
      default: return 200000;
    endcase
  endfunction

  // Load n non-overlapping exons, listed in transcription order for the current strand
  function automatic void load_transcript(int n);
    longint len [ecm_pkg::MAX_EXONS];
    longint gap [ecm_pkg::MAX_EXONS];
    longint span;
    longint base;
    longint cur;
    int     lmax;
    int     gmax;
    int     k;
    int     slot;
    lmax = pick_scale();
    gmax = pick_scale();
    span = 0;
    for (k = 0; k < n; k++) begin
      len[k] = $urandom_range(lmax, 1);
      gap[k] = (k == 0) ? 0 : $urandom_range(gmax, 0);
      span += len[k] + gap[k];
    end
    case ($urandom_range(3))
      0:       base = 0;
      1:       base = POS_MAX + 1 - span;
      default: base = $urandom_range(32'(POS_MAX - span));
    endcase
    cur = base;
    for (k = 0; k < n; k++) begin
      cur += gap[k];
      slot = plan_minus ? n - 1 - k : k;
      add_item(ecm_pkg::OP_WRITE, ecm_pkg::IDX_W'(slot), ecm_pkg::POS_W'(cur),
               ecm_pkg::POS_W'(cur + len[k] - 1), $urandom());
      cur += len[k];
    end
  endfunction

  function automatic logic [ecm_pkg::POS_W-1:0] pick_genomic();
    logic [ecm_pkg::POS_W-1:0] lo;
    logic [ecm_pkg::POS_W-1:0] hi;
    int                        n;
    int                        k;
    n = active_exons();
    if (n == 0) return $urandom();
    k = $urandom_range(n - 1);
    lo = plan_first[k];
    hi = plan_last[k];
    case ($urandom_range(9))
      0, 1:    return lo;
      2:       return hi;
      3, 4, 5: return (hi >= lo) ? lo + $urandom_range(hi - lo) : lo;
      6:       return lo - 1;
      7:       return hi + 1;
      8:       return $urandom();
      default: return $urandom_range(1) ? {ecm_pkg::POS_W{1'b1}} : {ecm_pkg::POS_W{1'b0}};
    endcase
  endfunction

  function automatic logic [ecm_pkg::POS_W-1:0] pick_offset();
    longint total;
    longint cut;
    int     n;
    int     k;
    int     i;
    n = active_exons();
    if (n == 0) return $urandom_range(3);
    k = $urandom_range(n - 1);
    total = 0;
    cut = 0;
    for (i = 0; i < n; i++) begin
      total += longint'({32'd0, plan_last[i]}) - longint'({32'd0, plan_first[i]}) + 1;
      if (i == k) cut = total;
    end
    if (total <= 0 || total > POS_MAX) return $urandom();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ecm_pkg::POS_W'(total - 1);
      2:       return ecm_pkg::POS_W'(total);
      3:       return ecm_pkg::POS_W'(cut - 1);
      4:       return ecm_pkg::POS_W'(cut);
      5:       return $urandom();
      default: return ecm_pkg::POS_W'($urandom_range(32'(total - 1)));
    endcase
  endfunction

  function automatic void add_phase_traffic(int count);
    int j;
    for (j = 0; j < count; j++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: add_query(ecm_pkg::OP_G2S, pick_genomic());
        6, 7, 8, 9, 10:   add_query(ecm_pkg::OP_S2G, pick_offset());
        11, 12, 13, 14:   add_query(ecm_pkg::OP_G2U, pick_genomic());
        15, 16:           add_query(ecm_pkg::OP_LEN, $urandom());
        17:               add_item(ecm_pkg::OP_WRITE, ecm_pkg::IDX_W'($urandom()),
                                   $urandom(), $urandom(), $urandom());
        18: begin
          case ($urandom_range(2))
            0:       add_query(OP_SPARE_5, $urandom());
            1:       add_query(OP_SPARE_6, $urandom());
            default: add_query(OP_SPARE_7, $urandom());
          endcase
        end
        default: begin
          // reload a fresh table where that is cheap
          if (active_exons() <= 16) load_transcript(active_exons() == 0 ? 1 : active_exons());
          else add_query(ecm_pkg::OP_LEN, $urandom());
        end
      endcase
    end
  endfunction

  function automatic void set_idling(int mode);
    case (mode)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 60; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 60; end
      default: begin send_idle = 35; recv_stall = 35; end
    endcase
  endfunction

  // Hold until every request is taken and every result has come back;
  // check at the rising edge, where the request valid is steady
  task automatic settle();
    do
      @(posedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || pending_maps.size() != 0);
    @(negedge clk);
  endtask

  task automatic write_config(bit minus, int count);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= ecm_pkg::CFG_STRAND;
    cfg_data <= ecm_pkg::CNT_W'(minus);
    @(negedge clk);
    cfg_index <= ecm_pkg::CFG_COUNT;
    cfg_data <= ecm_pkg::CNT_W'(count);
    @(negedge clk);
    cfg_we <= 1'b0;
    plan_minus = minus;
    plan_count = count;
  endtask

  // Request driver and response ready
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      req_taken = 1'b0;
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
        next_req = req_backlog.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.op <= next_req.op;
        req_ch.exon_slot <= next_req.slot;
        req_ch.exon_first <= next_req.first;
        req_ch.exon_last <= next_req.last;
        req_ch.position <= next_req.position;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Monitor: check results first, then predict for the request taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      tbl_minus = 1'b0;
      tbl_count = ecm_pkg::CNT_W'(1);
      req_taken = 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_maps.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result: expected none, got mapped_position %h found %b",
                     $time, rsp_ch.mapped_position, rsp_ch.found);
        end else begin
          due = pending_maps.pop_front();
          if (due.mapped !== rsp_ch.mapped_position) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: mapped_position expected %h, got %h",
                       $time, due.mapped, rsp_ch.mapped_position);
          end
          if (due.found !== rsp_ch.found) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: found expected %b, got %b", $time, due.found, rsp_ch.found);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ecm_pkg::CFG_STRAND: tbl_minus = cfg_data[0];
          ecm_pkg::CFG_COUNT:  tbl_count = cfg_data;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        predicted = predict_mapping({req_ch.op, req_ch.exon_slot, req_ch.exon_first,
                                     req_ch.exon_last, req_ch.position});
        pending_maps = {pending_maps, predicted};
        req_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int  phase;
    int  random_base;
    int  count;
    int  active;
    bit  minus;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = ecm_pkg::CFG_STRAND;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = ecm_pkg::OP_WRITE;
    req_ch.exon_slot = '0;
    req_ch.exon_first = '0;
    req_ch.exon_last = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;
    plan_minus = 1'b0;
    plan_count = 1;
    mismatches = 0;
    cycles = 0;
    items_made = 0;
    set_idling(0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Plus strand, one exon, reset settings
    add_item(ecm_pkg::OP_WRITE, '0, 32'd100, 32'd199, '0);
    add_query(ecm_pkg::OP_G2S, 32'd100);
    add_query(ecm_pkg::OP_G2S, 32'd199);
    add_query(ecm_pkg::OP_G2S, 32'd99);
    add_query(ecm_pkg::OP_G2S, 32'd200);
    add_query(ecm_pkg::OP_S2G, 32'd0);
    add_query(ecm_pkg::OP_S2G, 32'd99);
    add_query(ecm_pkg::OP_S2G, 32'd100);
    add_query(ecm_pkg::OP_G2U, 32'd150);
    add_query(ecm_pkg::OP_LEN, '1);
    add_query(OP_SPARE_5, 32'd100);
    add_query(OP_SPARE_6, 32'd100);
    add_query(OP_SPARE_7, 32'd100);

    // Empty table
    write_config(1'b1, 0);
    add_query(ecm_pkg::OP_G2S, 32'd150);
    add_query(ecm_pkg::OP_S2G, 32'd0);
    add_query(ecm_pkg::OP_G2U, 32'd150);
    add_query(ecm_pkg::OP_LEN, '0);

    // Minus strand, exons at both ends of the coordinate range
    write_config(1'b1, 2);
    add_item(ecm_pkg::OP_WRITE, ecm_pkg::IDX_W'(0), 32'hFFFF_FF00, '1, '0);
    add_item(ecm_pkg::OP_WRITE, ecm_pkg::IDX_W'(1), '0, 32'h0000_00FF, '1);
    add_item(ecm_pkg::OP_WRITE, '1, '1, '0, '0);
    add_query(ecm_pkg::OP_G2S, '1);
    add_query(ecm_pkg::OP_G2S, '0);
    add_query(ecm_pkg::OP_S2G, '0);
    add_query(ecm_pkg::OP_S2G, 32'd511);
    add_query(ecm_pkg::OP_G2U, '0);
    add_query(ecm_pkg::OP_LEN, '0);
    // reversed exon drives the spliced length negative
    add_item(ecm_pkg::OP_WRITE, ecm_pkg::IDX_W'(1), '1, '0, '0);
    add_query(ecm_pkg::OP_LEN, '0);

    random_base = items_made;
    for (phase = 0; items_made - random_base < TARGET_ITEMS; phase++) begin
      minus = $urandom_range(1);
      case ($urandom_range(19))
        0:       count = 0;
        1:       count = ecm_pkg::MAX_EXONS;
        2:       count = $urandom_range(127, ecm_pkg::MAX_EXONS + 1);
        3, 4:    count = $urandom_range(ecm_pkg::MAX_EXONS - 1, 13);
        default: count = $urandom_range(12, 1);
      endcase
      // saturated and full tables early on, one per strand
      if (phase == 0) begin
        minus = 1'b1;
        count = 127;
      end else if (phase == 1) begin
        minus = 1'b0;
        count = ecm_pkg::MAX_EXONS;
      end
      write_config(minus, count);
      set_idling(phase % 4);
      active = active_exons();
      load_transcript(active == 0 ? 1 : active);
      add_phase_traffic(PHASE_ITEMS);
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_maps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- exon_coordinate_mapper.f -----
+incdir+rtl/core
rtl/core/ecm_pkg.sv
rtl/core/ecm_if.sv
rtl/core/ecm_datapath.sv
rtl/core/ecm_ctrl.sv
rtl/core/exon_coordinate_mapper.sv
rtl/core/ecm_checker.sv
tb/tb.sv
